// File: rtl/core/mos_pkg.sv
// shared types and constants for the median-of-sample-set block
// no dependencies; imported by the channel interfaces and every module
`default_nettype none

package mos_pkg;

   // default configuration
   localparam int MAX_SAMPLES_DEF = 64;
   localparam int SAMPLE_BITS_DEF = 32;

   // request opcodes (code 3 is unused and ignored)
   typedef enum logic [1:0] {
      OP_ADD        = 2'd0,
      OP_ADD_FINISH = 2'd1,
      OP_FINISH     = 2'd2
   } op_type;

   // read address source of the sample store
   typedef enum logic [1:0] {
      RD_POS_PREV = 2'd0,
      RD_MID_LO   = 2'd1,
      RD_MID_HI   = 2'd2
   } rd_sel_type;

   // how the result is formed
   typedef enum logic [1:0] {
      RSP_EMPTY = 2'd0,
      RSP_ODD   = 2'd1,
      RSP_EVEN  = 2'd2
   } rsp_mode_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_CHK,
      ST_INS_CMP,
      ST_MED_START,
      ST_MED_LO,
      ST_MED_ODD,
      ST_MED_EVEN,
      ST_MED_EMPTY
   } ctrl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic         load;
      logic         drop;
      logic         rd_en;
      rd_sel_type   rd_sel;
      logic         wr_shift;
      logic         wr_new;
      logic         cap_lo;
      logic         rsp_load;
      rsp_mode_type rsp_mode;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic full;
      logic pos_zero;
      logic less;
      logic count_zero;
      logic count_odd;
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

// File: rtl/core/mos_chan_if.sv
// request and response channel interfaces for the median-of-sample-set block
// depends on mos_pkg for default widths
`default_nettype none

interface mos_req_if
   import mos_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic [1:0]                    opcode;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output opcode, output sample, input ready);
   modport sink   (input valid, input opcode, input sample, output ready);
endinterface

interface mos_rsp_if
   import mos_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic signed [SAMPLE_BITS-1:0] median;
   logic                          overflowed;

   modport source (output valid, output found, output median, output overflowed,
                   input ready);
   modport sink   (input valid, input found, input median, input overflowed,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/core/mos_ctrl.sv
// controller state machine: sequences insertion, median read-out and result load
// depends on mos_pkg for state, command and status types
`default_nettype none

module mos_ctrl
   import mos_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire logic [1:0]    in_opcode,
   input  wire dp_status_type status,
   output logic               in_ready,
   output dp_cmd_type         cmd
);

   ctrl_state_type state_ff, state_in;
   logic           finish_ff, finish_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         finish_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         finish_ff <= finish_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      finish_in = finish_ff;
      in_ready  = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               unique case (op_type'(in_opcode))
                  OP_ADD, OP_ADD_FINISH: begin
                     cmd.load  = 1'b1;
                     finish_in = (op_type'(in_opcode) == OP_ADD_FINISH);
                     if (status.full) begin
                        cmd.drop = 1'b1;
                        state_in = (op_type'(in_opcode) == OP_ADD_FINISH) ?
                                   ST_MED_START : ST_IDLE;
                     end else begin
                        state_in = ST_INS_CHK;
                     end
                  end
                  OP_FINISH: begin
                     state_in = ST_MED_START;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         // bottom reached: place the sample, else fetch the entry below
         ST_INS_CHK: begin
            if (status.pos_zero) begin
               cmd.wr_new = 1'b1;
               state_in   = finish_ff ? ST_MED_START : ST_IDLE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_POS_PREV;
               state_in   = ST_INS_CMP;
            end
         end
         // larger entry moves up one place, otherwise the sample lands here
         ST_INS_CMP: begin
            if (status.less) begin
               cmd.wr_shift = 1'b1;
               state_in     = ST_INS_CHK;
            end else begin
               cmd.wr_new = 1'b1;
               state_in   = finish_ff ? ST_MED_START : ST_IDLE;
            end
         end
         ST_MED_START: begin
            if (status.count_zero) begin
               state_in = ST_MED_EMPTY;
            end else if (status.count_odd) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_MID_HI;
               state_in   = ST_MED_ODD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_MID_LO;
               state_in   = ST_MED_LO;
            end
         end
         ST_MED_LO: begin
            cmd.cap_lo = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_MID_HI;
            state_in   = ST_MED_EVEN;
         end
         // wait for the output slot, then load the result
         ST_MED_ODD: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_mode = RSP_ODD;
               state_in     = ST_IDLE;
            end
         end
         ST_MED_EVEN: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_mode = RSP_EVEN;
               state_in     = ST_IDLE;
            end
         end
         ST_MED_EMPTY: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_mode = RSP_EMPTY;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/core/mos_datapath.sv
// datapath: sorted sample store, insertion pointer, median arithmetic, result register
// depends on mos_pkg for command and status types
`default_nettype none

module mos_datapath
   import mos_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dp_cmd_type                    cmd,
   output dp_status_type                      status,
   input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic signed [SAMPLE_BITS-1:0]      rsp_median,
   output logic                               rsp_overflowed
);

   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_SAMPLES);
   localparam logic [CW-1:0] ONE       = CW'(1);

   // sample store, ascending order
   logic signed [SAMPLE_BITS-1:0] store_mem [MAX_SAMPLES];

   logic [CW-1:0]                 count_ff, count_in;
   logic                          ovf_ff, ovf_in;
   logic [CW-1:0]                 pos_ff, pos_in;
   logic signed [SAMPLE_BITS-1:0] new_ff, new_in;
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic signed [SAMPLE_BITS-1:0] lo_ff, lo_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic signed [SAMPLE_BITS-1:0] rsp_median_ff, rsp_median_in;
   logic                          rsp_ovf_ff, rsp_ovf_in;

   logic [CW-1:0]                 pos_prev, mid_hi, mid_lo;
   logic [AW-1:0]                 rd_addr;
   logic                          wr_en;
   logic signed [SAMPLE_BITS-1:0] wr_data;
   logic signed [SAMPLE_BITS-1:0] avg_xor, avg;

   // store addresses
   always_comb begin
      pos_prev = pos_ff - ONE;
      mid_hi   = count_ff >> 1;
      mid_lo   = mid_hi - ONE;
      unique case (cmd.rd_sel)
         RD_POS_PREV: rd_addr = pos_prev[AW-1:0];
         RD_MID_LO:   rd_addr = mid_lo[AW-1:0];
         RD_MID_HI:   rd_addr = mid_hi[AW-1:0];
         default:     rd_addr = pos_prev[AW-1:0];
      endcase
      wr_en   = cmd.wr_shift | cmd.wr_new;
      wr_data = cmd.wr_shift ? rd_data_ff : new_ff;
   end

   // store write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[pos_ff[AW-1:0]] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // floor average of the two middle values without a wider sum
   always_comb begin
      avg_xor = lo_ff ^ rd_data_ff;
      avg     = (lo_ff & rd_data_ff) + (avg_xor >>> 1);
   end

   // set bookkeeping and result register next values
   always_comb begin
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      pos_in        = pos_ff;
      new_in        = new_ff;
      lo_in         = lo_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_median_in = rsp_median_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      if (cmd.load) begin
         new_in = in_sample;
         pos_in = count_ff;
      end
      if (cmd.drop) begin
         ovf_in = 1'b1;
      end
      if (cmd.wr_shift) begin
         pos_in = pos_prev;
      end
      if (cmd.wr_new) begin
         count_in = count_ff + ONE;
      end
      if (cmd.cap_lo) begin
         lo_in = rd_data_ff;
      end

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_ovf_in   = ovf_ff;
         unique case (cmd.rsp_mode)
            RSP_ODD: begin
               rsp_found_in  = 1'b1;
               rsp_median_in = rd_data_ff;
            end
            RSP_EVEN: begin
               rsp_found_in  = 1'b1;
               rsp_median_in = avg;
            end
            default: begin
               rsp_found_in  = 1'b0;
               rsp_median_in = '0;
            end
         endcase
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      new_ff        <= new_in;
      lo_ff         <= lo_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_median_ff <= rsp_median_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   // status to the controller
   always_comb begin
      status.full       = (count_ff == MAX_COUNT);
      status.pos_zero   = (pos_ff == '0);
      status.less       = (new_ff < rd_data_ff);
      status.count_zero = (count_ff == '0);
      status.count_odd  = count_ff[0];
      status.rsp_free   = ~rsp_valid_ff | rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_median     = rsp_median_ff;
   assign rsp_overflowed = rsp_ovf_ff;

endmodule

`default_nettype wire

// File: rtl/core/median_of_sample_set.sv
// Median of a sample set. Signed fixed-point samples arrive on the request
// channel (opcode add, add and finish, finish) and are kept in ascending order
// in a single-port-style store of MAX_SAMPLES entries; each finish returns one
// response with a found flag, the median (floor average of the two middle
// values for an even count) and an overflow flag for samples dropped once the
// store was full. The store gives one registered read and one write per
// cycle. An add walks down from the top of the set: it reads the entry below
// its place and moves it up one place if it is larger, else writes the sample;
// at the bottom it writes the sample. A sample that meets a full store is
// dropped. A finish reads the middle entry for an odd count, or the lower
// then the upper middle entry for an even one, and then waits for the output
// slot to load the response. Responses sit in an output register, so adds are
// taken while a response waits; a finish holds until that register is free.
// No clearing pass is needed after reset. Opcode 3 is accepted and ignored.
// depends on mos_pkg, mos_chan_if, mos_ctrl and mos_datapath
`default_nettype none

module median_of_sample_set
   import mos_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   mos_req_if.sink   req_ch,
   mos_rsp_if.source rsp_ch
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          in_ready;

   // controller
   mos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_opcode (req_ch.opcode),
      .status    (status),
      .in_ready  (in_ready),
      .cmd       (cmd)
   );

   // datapath
   mos_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .in_sample      (req_ch.sample),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_found      (rsp_ch.found),
      .rsp_median     (rsp_ch.median),
      .rsp_overflowed (rsp_ch.overflowed)
   );

   assign req_ch.ready = in_ready;

   // a response is only loaded into a free output slot
   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.rsp_free)
      else $error("response loaded over a pending transfer");

   // a loaded response is presented in the next cycle
   a_rsp_presented: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_ch.valid)
      else $error("loaded response not presented");

   // shifting never runs past the bottom of the store
   a_shift_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_shift |-> !status.pos_zero)
      else $error("shift below the first entry");

   // a sample is only placed while the store has room
   a_place_room: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_new |-> !status.full)
      else $error("sample placed into a full store");

endmodule

`default_nettype wire

// File: tb/sv/median_of_sample_set_tb.sv
// testbench for median_of_sample_set: random and directed sample sets, each
// response checked against an in-bench sorted-store predictor
// depends on mos_pkg, mos_chan_if and the median_of_sample_set rtl
module median_of_sample_set_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mos_pkg::*;

   localparam int STORE_DEPTH = MAX_SAMPLES_DEF;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // margin for the longest add, which moves every stored sample, plus a finish
   localparam int SETTLE_CYCLES = 2 * STORE_DEPTH + 16;
   localparam int ITEMS_PER_PHASE = 470;

   typedef struct {
      logic [1:0]  opcode;
      logic [31:0] sample;
   } sample_item_type;

   typedef struct {
      logic        found;
      logic [31:0] median;
      logic        overflowed;
   } median_result_type;

   logic clock = 1'b0;
   logic reset;

   mos_req_if req_bus ();
   mos_rsp_if rsp_bus ();

   median_of_sample_set u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // predictor state: ascending store, count held, drop seen in this set
   logic signed [31:0] sorted_store [STORE_DEPTH];
   int                 held_count = 0;
   bit                 drop_seen  = 1'b0;

   sample_item_type   samples_to_send [$];
   median_result_type medians_due [$];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   bit          req_taken;
   int unsigned error_count = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // insert a sample or close the set; returns 1 when a response is due
   function automatic bit predict_median(input sample_item_type item,
                                         output median_result_type res);
      int                 pos;
      int                 n;
      logic signed [31:0] v;
      logic signed [32:0] pair_sum;
      res.found      = 1'b0;
      res.median     = '0;
      res.overflowed = 1'b0;
      if (item.opcode == OP_UNUSED) return 1'b0;
      if (item.opcode != OP_FINISH) begin
         v = item.sample;
         if (held_count >= STORE_DEPTH) begin
            drop_seen = 1'b1;
         end else begin
            // equal samples stay ahead of the new one
            pos = held_count;
            while (pos > 0 && v < sorted_store[pos-1]) begin
               sorted_store[pos] = sorted_store[pos-1];
               pos--;
            end
            sorted_store[pos] = v;
            held_count++;
         end
      end
      if (item.opcode == OP_ADD) return 1'b0;
      n = held_count;
      if (n > 0) begin
         res.found = 1'b1;
         if (n % 2 == 1) begin
            res.median = sorted_store[(n-1)/2];
         end else begin
            // exact sum then drop the low bit: floor of the average
            pair_sum = {sorted_store[n/2-1][31], sorted_store[n/2-1]}
                     + {sorted_store[n/2][31], sorted_store[n/2]};
            res.median = pair_sum[32:1];
         end
      end
      res.overflowed = drop_seen;
      held_count = 0;
      drop_seen  = 1'b0;
      return 1'b1;
   endfunction

   function automatic void enqueue_request(input logic [1:0] opcode,
                                           input logic [31:0] sample);
      sample_item_type it;
      it.opcode = opcode;
      it.sample = sample;
      samples_to_send = {samples_to_send, it};
   endfunction

   // one well-formed set of random shape; returns the items that count
   function automatic int unsigned queue_random_set(input int unsigned size);
      int unsigned k;
      int unsigned style;
      int unsigned count;
      logic [31:0] base;
      logic [31:0] value;
      bit          last_finishes;
      style = $urandom_range(4);
      base  = $urandom;
      count = 0;
      last_finishes = (size != 0) && ($urandom_range(1) == 1);
      for (k = 0; k < size; k++) begin
         case (style)
            0: value = $urandom;
            1: value = base + $urandom_range(6) - 3;
            2: value = base + (k << 12);
            3: value = base - (k << 12);
            default: value = $urandom_range(32'h000fffff) - 32'h00080000;
         endcase
         if ($urandom_range(15) == 0)
            value = ($urandom_range(1) == 1) ? 32'h7fffffff : 32'h80000000;
         // occasional unused opcode as noise
         if ($urandom_range(31) == 0) enqueue_request(OP_UNUSED, $urandom);
         enqueue_request((last_finishes && k == size - 1) ? OP_ADD_FINISH : OP_ADD,
                         value);
         count++;
      end
      if (!last_finishes) begin
         enqueue_request(OP_FINISH, $urandom);
         count++;
      end
      return count;
   endfunction

   task automatic wait_for_drain();
      do @(posedge clock);
      while (samples_to_send.size() != 0 || req_bus.valid || medians_due.size() != 0);
   endtask

   // request driver and response stall, both on the falling edge
   always @(negedge clock) begin : drive_channels
      sample_item_type next_item;
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (!req_bus.valid || req_taken) begin
            if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = samples_to_send.pop_front();
               req_bus.valid  <= 1'b1;
               req_bus.opcode <= next_item.opcode;
               req_bus.sample <= next_item.sample;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // transfer monitor: check responses, then predict from accepted requests
   always @(posedge clock) begin : watch_channels
      median_result_type due;
      sample_item_type   taken;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (medians_due.size() == 0) begin
               $error("response transfer with no finish pending");
               error_count++;
            end else begin
               due = medians_due.pop_front();
               if (rsp_bus.found !== due.found) begin
                  $error("found: expected %0b, got %0b", due.found, rsp_bus.found);
                  error_count++;
               end
               if (rsp_bus.median !== due.median) begin
                  $error("median: expected %h, got %h", due.median, rsp_bus.median);
                  error_count++;
               end
               if (rsp_bus.overflowed !== due.overflowed) begin
                  $error("overflowed: expected %0b, got %0b",
                         due.overflowed, rsp_bus.overflowed);
                  error_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            taken.opcode = req_bus.opcode;
            taken.sample = req_bus.sample;
            if (predict_median(taken, due)) medians_due = {medians_due, due};
         end
      end
   end

   // stimulus: directed sets, then three random phases of differing stalls
   initial begin : run_stimulus
      int unsigned phase;
      int unsigned queued;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.opcode = OP_ADD;
      req_bus.sample = '0;
      rsp_bus.ready  = 1'b0;
      send_idle_pct  = 37;
      recv_idle_pct  = 74;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 37;
               recv_idle_pct = 74;
            end
            1: begin
               send_idle_pct = 74;
               recv_idle_pct = 37;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (phase == 0) begin
            // empty set, then unused opcode on its own
            enqueue_request(OP_FINISH, 32'h0);
            enqueue_request(OP_UNUSED, 32'h12345678);
            // single extremes
            enqueue_request(OP_ADD_FINISH, 32'h7fffffff);
            enqueue_request(OP_ADD_FINISH, 32'h80000000);
            // even pairs at the extremes: no overflow in the average
            enqueue_request(OP_ADD, 32'h80000000);
            enqueue_request(OP_ADD_FINISH, 32'h7fffffff);
            enqueue_request(OP_ADD, 32'h7fffffff);
            enqueue_request(OP_ADD_FINISH, 32'h7fffffff);
            enqueue_request(OP_ADD, 32'h80000000);
            enqueue_request(OP_ADD_FINISH, 32'h80000000);
            // half-way average rounds towards minus infinity
            enqueue_request(OP_ADD, 32'hffffffff);
            enqueue_request(OP_ADD_FINISH, 32'h00000000);
            // equal samples
            enqueue_request(OP_ADD, 32'h00030000);
            enqueue_request(OP_ADD, 32'h00030000);
            enqueue_request(OP_ADD, 32'h00010000);
            enqueue_request(OP_ADD, 32'h00030000);
            enqueue_request(OP_FINISH, 32'h0);
            // odd set closed by a finish whose sample is ignored
            enqueue_request(OP_ADD, 32'h00050000);
            enqueue_request(OP_ADD, 32'hfffb0000);
            enqueue_request(OP_ADD, 32'h00018000);
            enqueue_request(OP_FINISH, 32'h7fffffff);
            // unused opcode inside a set
            enqueue_request(OP_ADD, 32'h000a0000);
            enqueue_request(OP_UNUSED, 32'h00140000);
            enqueue_request(OP_ADD_FINISH, 32'h001e0000);
            // store exactly full, then run past capacity
            queued = queue_random_set(STORE_DEPTH);
            queued = queue_random_set(STORE_DEPTH + 6);
         end
         // directed items already queued count towards this phase
         queued = samples_to_send.size();
         while (queued < ITEMS_PER_PHASE) begin
            case ($urandom_range(19))
               0:       queued += queue_random_set($urandom_range(STORE_DEPTH + 8,
                                                                  STORE_DEPTH - 8));
               1, 2, 3: queued += queue_random_set($urandom_range(40, 9));
               default: queued += queue_random_set($urandom_range(8));
            endcase
         end
         wait_for_drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #3_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
